// ===== rtl/fbs_pkg.sv =====
package fbs_pkg;

  // default sizing of the key table
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_WIDTH   = 32;

  // configuration port sizing
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 9;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_SIGNED = CFG_INDEX_W'(1);

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // one request item
  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic [31:0] key_value;
  } fbs_in_t;

  // one search result
  typedef struct packed {
    logic       found_any;
    logic       exact_match;
    logic [7:0] result_index;
  } fbs_out_t;

endpackage

// ===== rtl/floor_binary_search.sv =====
// Sorted key table with floor search. A write item (opcode 0) stores key_value into slot
// entry_index and gives no result; a slot at or above TABLE_DEPTH is dropped.
// A search item (opcode 1) gives one result: the index of an entry equal to the key, or of
// the greatest entry below it, or found_any = 0 when entry_count is zero or the key lies
// below entry 0. The table must be loaded in ascending order under the compare mode chosen
// by compare_signed, and only slots below entry_count may be searched. A search runs through
// these steps, n being the clamped entry_count: taking the item, the entry 0 check
// (skipped when n is zero), the halving probes, and handing the answer to the result
// register. The request side is stalled for all but the first of those steps, and longer
// while an earlier answer still waits on rsp_stall. Each probe needs one read of the key
// memory's single read port, which paces the search. Write items leave the sequencer idle.
// The result register lets a new item be taken while the previous answer still waits on
// rsp_stall. Configuration is written through cfg_valid and cfg_ready, which is always
// high, and must only change while the block is idle.
module floor_binary_search #(
  parameter int TABLE_DEPTH = fbs_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = fbs_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  fbs_pkg::fbs_in_t                    req_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output fbs_pkg::fbs_out_t                   rsp_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fbs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHK0  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]           state, state_next;
  logic [CNT_W-1:0]     low, low_next;
  logic [CNT_W-1:0]     len, len_next;
  logic [IDX_W-1:0]     probe, probe_next;
  fbs_out_t             res, res_next;
  logic [KEY_WIDTH-1:0] key;
  logic [8:0]           entry_count;
  logic                 compare_signed;

  logic                 req_xfer, rsp_xfer, rsp_free;
  logic                 wr_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [CNT_W-1:0]     n_clamp;
  logic [KEY_WIDTH-1:0] key_x, tab_x;
  logic                 key_lt, key_eq;
  logic [CNT_W-1:0]     low_adv, len_adv;

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign rsp_xfer  = rsp_valid && !rsp_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      compare_signed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENTRY_COUNT:    entry_count    <= cfg_data[8:0];
        REG_COMPARE_SIGNED: compare_signed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // table write on a write-item transfer inside the table
  assign wr_en = req_xfer && (req_data.opcode == OP_WRITE) &&
                 (int'(req_data.entry_index) < TABLE_DEPTH);

  fbs_key_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(req_data.entry_index)),
    .wr_key  (KEY_WIDTH'(req_data.key_value)),
    .rd_addr (rd_addr),
    .rd_key  (rd_key)
  );

  // live entry count, clamped to the table depth
  assign n_clamp = (int'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(entry_count);

  // shared key comparator, sign bit flipped for two's complement order
  assign key_x  = compare_signed ? (key ^ SIGN_BIT) : key;
  assign tab_x  = compare_signed ? (rd_key ^ SIGN_BIT) : rd_key;
  assign key_lt = (key_x < tab_x);
  assign key_eq = (key_x == tab_x);

  // next search window after a probe that missed
  always_comb begin
    if (!key_lt) begin
      low_adv = CNT_W'(probe) + CNT_W'(1);
      len_adv = len - (len >> 1) - CNT_W'(1);
    end else begin
      low_adv = low;
      len_adv = len >> 1;
    end
  end

  // search sequencer
  always_comb begin
    state_next = state;
    low_next   = low;
    len_next   = len;
    probe_next = probe;
    res_next   = res;
    rd_addr    = probe;
    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (req_xfer && (req_data.opcode == OP_SEARCH)) begin
          len_next = n_clamp;
          if (n_clamp == '0) begin
            res_next   = '0;
            state_next = S_DONE;
          end else begin
            state_next = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (key_lt) begin
          res_next   = '0;
          state_next = S_DONE;
        end else if (key_eq) begin
          res_next   = '{found_any: 1'b1, exact_match: 1'b1, result_index: 8'd0};
          state_next = S_DONE;
        end else begin
          low_next   = '0;
          probe_next = IDX_W'(len >> 1);
          rd_addr    = probe_next;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (key_eq) begin
          res_next   = '{found_any: 1'b1, exact_match: 1'b1, result_index: 8'(probe)};
          state_next = S_DONE;
        end else if (len_adv == '0) begin
          // window empty: last probe if below the key, else the entry before it
          res_next.found_any   = 1'b1;
          res_next.exact_match = 1'b0;
          if (!key_lt) begin
            res_next.result_index = 8'(probe);
          end else if (probe != '0) begin
            res_next.result_index = 8'(probe - IDX_W'(1));
          end else begin
            res_next.result_index = 8'd0;
          end
          state_next = S_DONE;
        end else begin
          low_next   = low_adv;
          len_next   = len_adv;
          probe_next = IDX_W'(low_adv + (len_adv >> 1));
          rd_addr    = probe_next;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search working registers
  always_ff @(posedge clk) begin
    low   <= low_next;
    len   <= len_next;
    probe <= probe_next;
    res   <= res_next;
    if (req_xfer) begin
      key <= KEY_WIDTH'(req_data.key_value);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_xfer) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && rsp_free) begin
      rsp_data <= res;
    end
  end

  // a search transfer starts the entry 0 check or finishes at once
  a_search_start: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && (req_data.opcode == OP_SEARCH)) |=> (state == S_CHK0 || state == S_DONE))
    else $error("search transfer did not start a search");

  // a write transfer never disturbs the sequencer
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && (req_data.opcode == OP_WRITE)) |=> (state == S_IDLE))
    else $error("write transfer left idle");

  // probing only runs with a non-empty window
  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (len != '0))
    else $error("probe with empty window");

  // an exact match always counts as found
  a_exact_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.exact_match) |-> rsp_data.found_any)
    else $error("exact match without found");

  // a miss reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.found_any) |-> (rsp_data.result_index == 8'd0))
    else $error("miss with nonzero index");

endmodule

// ===== rtl/fbs_key_table.sv =====
module fbs_key_table #(
  parameter int TABLE_DEPTH = fbs_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = fbs_pkg::DEF_KEY_WIDTH,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [KEY_WIDTH-1:0] wr_key,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [KEY_WIDTH-1:0] rd_key
);
  import fbs_pkg::*;

  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_key;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key <= mem[rd_addr];
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import fbs_pkg::*;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 250;
  localparam int REPORT_LIMIT   = 50;
  localparam int RANDOM_TARGET  = 430;
  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  // floor search predictor and queue of answers still owed by the block
  class floor_answer_board;
    logic [31:0] key_store [DEF_TABLE_DEPTH];
    logic [8:0]  live_count;
    bit          signed_keys;
    fbs_out_t    answers_due [$];
    int          mismatch_count;

    function new();
      foreach (key_store[i]) key_store[i] = '0;
      live_count     = '0;
      signed_keys    = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ENTRY_COUNT) live_count = data;
      else if (idx == REG_COMPARE_SIGNED) signed_keys = data[0];
    endfunction

    // three-way key compare; signed mode flips the top bit so unsigned order applies
    function int order_of(logic [31:0] a, logic [31:0] b);
      logic [31:0] ra, rb;
      ra = signed_keys ? a ^ SIGN_FLIP : a;
      rb = signed_keys ? b ^ SIGN_FLIP : b;
      if (ra < rb) return -1;
      if (ra > rb) return 1;
      return 0;
    endfunction

    // entry 0 check, then halving over the live part of the table
    function fbs_out_t floor_lookup(logic [31:0] key);
      fbs_out_t ans;
      int n, low, len, probe, half, ord;
      ans = '0;
      n = (live_count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(live_count);
      if (n == 0) return ans;
      ord = order_of(key, key_store[0]);
      if (ord < 0) return ans;
      if (ord == 0) begin
        ans.found_any   = 1'b1;
        ans.exact_match = 1'b1;
        return ans;
      end
      low   = 0;
      len   = n;
      probe = 0;
      while (len > 0) begin
        half  = len >> 1;
        probe = low + half;
        ord   = order_of(key, key_store[probe]);
        if (ord == 0) begin
          ans.found_any    = 1'b1;
          ans.exact_match  = 1'b1;
          ans.result_index = 8'(probe);
          return ans;
        end
        if (ord > 0) begin
          len -= half + 1;
          low  = probe + 1;
        end else begin
          len = half;
        end
      end
      // last probe answers if below the key, else the entry before it
      ans.found_any    = 1'b1;
      ans.result_index = (ord > 0) ? 8'(probe) : ((probe > 0) ? 8'(probe - 1) : 8'd0);
      return ans;
    endfunction

    function void note_request(fbs_in_t req);
      if (req.opcode == OP_WRITE) key_store[req.entry_index] = req.key_value;
      else answers_due.push_back(floor_lookup(req.key_value));
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $error("%s: expected %0h, actual %0h", field, want, got);
    endfunction

    function void check_answer(fbs_out_t got);
      fbs_out_t want;
      if (answers_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $error("result transfer with no search outstanding: %0h", got);
        return;
      end
      want = answers_due.pop_front();
      if (got.found_any !== want.found_any)
        report("found_any", want.found_any, got.found_any);
      if (got.exact_match !== want.exact_match)
        report("exact_match", want.exact_match, got.exact_match);
      if (got.result_index !== want.result_index)
        report("result_index", want.result_index, got.result_index);
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  fbs_in_t                req_data;
  logic                   rsp_valid;
  logic                   rsp_stall;
  fbs_out_t               rsp_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  floor_answer_board board = new();

  logic [31:0] loaded_keys [DEF_TABLE_DEPTH];
  bit          cur_signed;
  int          items_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  int          cycle_count;

  floor_binary_search uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) board.check_answer(rsp_data);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // maps a key into unsigned rank order under the current compare mode and back
  function automatic logic [31:0] rank_flip(logic [31:0] k);
    return cur_signed ? k ^ SIGN_FLIP : k;
  endfunction

  // one request transfer, with random idle cycles ahead of it
  task automatic send_item(logic op, logic [7:0] slot, logic [31:0] key);
    fbs_in_t req;
    int gap;
    if (items_sent < 170) begin
      send_idle_pct = 25;
      recv_idle_pct = 64;
    end else if (items_sent < 320) begin
      send_idle_pct = 64;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    req.opcode      = op;
    req.entry_index = slot;
    req.key_value   = key;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= req;
    do @(posedge clk); while (req_stall);
    board.note_request(req);
    if (op == OP_WRITE) loaded_keys[slot] = key;
    items_sent++;
  endtask

  // stop offering and let every owed answer arrive, then let the block settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // new register settings once idle; sometimes a write to an unused index too
  task automatic set_phase(logic [8:0] count, bit sgn);
    wait_idle();
    if ($urandom_range(3) == 0)
      cfg_write(CFG_INDEX_W'($urandom_range(15, 2)), CFG_DATA_W'($urandom()));
    cfg_write(REG_ENTRY_COUNT, count);
    cfg_write(REG_COMPARE_SIGNED, {8'($urandom()), sgn});
    cur_signed = sgn;
  endtask

  // ascending keys under the current mode, dense with repeats at times, or scrambled
  task automatic load_table(int n, bit scrambled);
    logic [31:0] rank, span;
    span = (n > 0) ? 32'hFFFF_FFFF / (n + 1) : 32'd0;
    if ($urandom_range(3) == 0) span = 32'd4;
    rank = $urandom_range(span);
    for (int i = 0; i < n; i++) begin
      send_item(OP_WRITE, 8'(i), scrambled ? 32'($urandom()) : rank_flip(rank));
      rank += $urandom_range(span);
    end
  endtask

  // search keys: mostly on or next to a live entry, some extremes, some random
  function automatic logic [31:0] pick_search_key(int n);
    logic [31:0] k;
    case ($urandom_range(9)) inside
      0: begin
        case ($urandom_range(3))
          0: k = 32'h0000_0000;
          1: k = 32'hFFFF_FFFF;
          2: k = 32'h8000_0000;
          default: k = 32'h7FFF_FFFF;
        endcase
      end
      1, 2: k = $urandom();
      default: begin
        if (n == 0) begin
          k = $urandom();
        end else begin
          k = rank_flip(loaded_keys[$urandom_range(n - 1)]);
          k = rank_flip(k + $urandom_range(2) - 1);
        end
      end
    endcase
    return k;
  endfunction

  // searches over the live entries, with the odd stray write mixed in
  task automatic search_batch(int n, int searches);
    for (int j = 0; j < searches; j++) begin
      if ($urandom_range(19) == 0)
        send_item(OP_WRITE, 8'($urandom_range(255)), $urandom());
      else
        send_item(OP_SEARCH, 8'($urandom_range(255)), pick_search_key(n));
    end
  endtask

  task automatic load_four(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2,
                           logic [31:0] k3);
    send_item(OP_WRITE, 8'd0, k0);
    send_item(OP_WRITE, 8'd1, k1);
    send_item(OP_WRITE, 8'd2, k2);
    send_item(OP_WRITE, 8'd3, k3);
  endtask

  // stimulus
  initial begin
    int          phase_no;
    logic [8:0]  count;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req_data      = '0;
    rsp_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cur_signed    = 1'b0;
    items_sent    = 0;
    send_idle_pct = 25;
    recv_idle_pct = 64;
    hold_requests = 0;
    hold_served   = 0;
    hold_left     = 0;
    cycle_count   = 0;
    foreach (loaded_keys[i]) loaded_keys[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table after reset: nothing found
    send_item(OP_SEARCH, 8'hFF, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 8'h00, 32'h0000_0000);

    // unsigned: below entry 0, exact at entry 0 and entry 2, floor in the middle, above all
    set_phase(9'd4, 1'b0);
    load_four(32'h0000_0010, 32'h0000_0100, 32'h8000_0000, 32'hFFFF_FFFE);
    send_item(OP_SEARCH, 8'h00, 32'h0000_0000);
    send_item(OP_SEARCH, 8'h55, 32'h0000_0010);
    send_item(OP_SEARCH, 8'hAA, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 8'h0F, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 8'hF0, 32'h8000_0000);

    // signed: most negative first, most positive last
    set_phase(9'd4, 1'b1);
    load_four(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 8'h00, 32'h8000_0000);
    send_item(OP_SEARCH, 8'h01, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 8'h02, 32'hFFFF_FFFE);
    send_item(OP_SEARCH, 8'h03, 32'h0000_0001);

    // one live entry, unsigned again
    set_phase(9'd1, 1'b0);
    send_item(OP_SEARCH, 8'h00, 32'h8000_0000);
    send_item(OP_SEARCH, 8'h00, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 8'h00, 32'hFFFF_FFFF);

    // random phases
    phase_no = 0;
    while (items_sent < RANDOM_TARGET) begin
      if (phase_no == 2) begin
        // full table, then a count beyond the table depth
        set_phase(9'(DEF_TABLE_DEPTH), 1'($urandom_range(1)));
        load_table(DEF_TABLE_DEPTH, 1'b0);
        search_batch(DEF_TABLE_DEPTH, 20);
        set_phase(9'h1FF, cur_signed);
        search_batch(DEF_TABLE_DEPTH, 12);
      end else begin
        case ($urandom_range(9))
          0: count = 9'd0;
          1: count = 9'd1;
          2: count = 9'($urandom_range(64, 17));
          default: count = 9'($urandom_range(16, 2));
        endcase
        set_phase(count, 1'($urandom_range(1)));
        load_table(int'(count), $urandom_range(9) == 0);
        // long result-side hold while requests keep coming
        if (phase_no == 1) hold_requests <= hold_requests + 1;
        search_batch(int'(count), $urandom_range(25, 10));
      end
      phase_no++;
    end

    wait_idle();
    if (board.mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== floor_binary_search.f =====
rtl/fbs_pkg.sv
rtl/fbs_key_table.sv
rtl/floor_binary_search.sv
dv/testbench.sv
